/* hw/rtl/bbp_pkg.sv */
// ----------------------------------------------------------------------------
// bbp_pkg
// Shared widths, field offsets and types for the bicubic Bezier patch evaluator.
// ----------------------------------------------------------------------------
package bbp_pkg;

  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int PARAM_W         = PARAM_FRAC_BITS + 1;
  localparam int INDEX_W         = 4;
  localparam int NUM_POINTS      = 16;

  // command codes carried on tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // request tdata layout, lowest bit first
  localparam int IN_INDEX_LO = 0;
  localparam int IN_X_LO     = IN_INDEX_LO + INDEX_W;
  localparam int IN_Y_LO     = IN_X_LO + COORD_BITS;
  localparam int IN_Z_LO     = IN_Y_LO + COORD_BITS;
  localparam int IN_U_LO     = IN_Z_LO + COORD_BITS;
  localparam int IN_V_LO     = IN_U_LO + PARAM_W;
  localparam int IN_FIELDS_W = IN_V_LO + PARAM_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // result tdata layout, lowest bit first
  localparam int OUT_FIELDS_W = 3 * COORD_BITS + 2 * PARAM_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [PARAM_W-1:0]           param_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

endpackage

/* hw/rtl/bbp_lerp.sv */
// ----------------------------------------------------------------------------
// bbp_lerp
// One de Casteljau step on a 3D point: p1 - round((p1 - p2) * t), saturated.
// ----------------------------------------------------------------------------
module bbp_lerp (
  input  bbp_pkg::point_t p1,
  input  bbp_pkg::point_t p2,
  input  bbp_pkg::param_t t,
  output bbp_pkg::point_t res
);

  localparam int PROD_W = bbp_pkg::COORD_BITS + bbp_pkg::PARAM_FRAC_BITS + 4;
  localparam logic signed [PROD_W-1:0] HALF =
    PROD_W'(1) <<< (bbp_pkg::PARAM_FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] SAT_MAX =
    (PROD_W'(1) <<< (bbp_pkg::COORD_BITS - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);

  function automatic bbp_pkg::coord_t lerp1(input bbp_pkg::coord_t a,
                                            input bbp_pkg::coord_t b,
                                            input bbp_pkg::param_t tp);
    logic signed [PROD_W-1:0] diff;
    logic signed [PROD_W-1:0] tt;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] r;
    logic signed [PROD_W-1:0] q;
    diff = PROD_W'(a) - PROD_W'(b);
    tt   = $signed(PROD_W'(tp));
    prod = diff * tt;
    r    = (prod + HALF) >>> bbp_pkg::PARAM_FRAC_BITS;  // floor after half-up bias
    q    = PROD_W'(a) - r;
    if (q > SAT_MAX) begin
      q = SAT_MAX;
    end else if (q < SAT_MIN) begin
      q = SAT_MIN;
    end
    return q[bbp_pkg::COORD_BITS-1:0];
  endfunction

  always_comb begin
    res.x = lerp1(p1.x, p2.x, t);
    res.y = lerp1(p1.y, p2.y, t);
    res.z = lerp1(p1.z, p2.z, t);
  end

endmodule

/* hw/rtl/bicubic_bezier_patch_eval.sv */
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval
// Bicubic Bezier patch evaluator, de Casteljau on one shared lerp unit.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_*: tuser is the command. A load request (tuser = 0)
//   writes one control point (x, y, z, signed Q4.12) at slot row*4+col and is
//   taken with no result. An evaluate request (tuser = 1) brings
//   u and v in Q1.16; values above one are clamped to one.
//   Master stream m_axis_*: one result per evaluate request, holding the
//   surface point and the texture pair (u, 1 - v).
// Sequence:
//   An evaluation runs from acceptance to the result register as follows:
//   per row, 4 registered point reads, then 6 lerp steps; then the row
//   results move into the work registers, 6 lerp steps run across them,
//   and the result is handed off to the output register.
//   All three coordinates go through the lerp unit together, one dependent
//   step per cycle. s_axis_tready is low for the whole evaluation, so no
//   new request is taken until the result is handed off.
// Reset and stalls:
//   rst clears the sequencer and the output valid. The point store is not
//   cleared; evaluating before all 16 points are loaded gives undefined data.
//   A finished result waits in the output register while new requests are
//   taken; only when a second result is ready and the first is still stalled
//   does the sequencer hold.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // point_index, load_x, load_y, load_z, param_u, param_v, zero pad
  input  logic [bbp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // cmd
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // surf_x, surf_y, surf_z, tex_s, tex_t, zero pad
  output logic [bbp_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;  // fetch one row of control points
  localparam logic [2:0] S_ULERP = 3'd2;  // six steps along a row at u
  localparam logic [2:0] S_VLOAD = 3'd3;  // row results into work registers
  localparam logic [2:0] S_VLERP = 3'd4;  // six steps across rows at v
  localparam logic [2:0] S_OUT   = 3'd5;  // hand off to output register

  logic [2:0] state;
  logic [1:0] row;
  logic [2:0] col;
  logic [2:0] step;

  bbp_pkg::point_t points [bbp_pkg::NUM_POINTS];
  bbp_pkg::point_t rd_data;
  bbp_pkg::point_t w [4];
  bbp_pkg::point_t rows [4];
  bbp_pkg::param_t u_reg;
  bbp_pkg::param_t v_reg;

  bbp_pkg::point_t op_a;
  bbp_pkg::point_t op_b;
  bbp_pkg::point_t lerp_res;
  bbp_pkg::param_t lerp_t;
  logic [1:0]      dest;

  bbp_pkg::param_t in_u;
  bbp_pkg::param_t in_v;
  bbp_pkg::point_t in_pt;
  logic [bbp_pkg::INDEX_W-1:0] in_index;
  logic accept;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_index = s_axis_tdata[bbp_pkg::IN_INDEX_LO +: bbp_pkg::INDEX_W];
  assign in_pt.x  = s_axis_tdata[bbp_pkg::IN_X_LO +: bbp_pkg::COORD_BITS];
  assign in_pt.y  = s_axis_tdata[bbp_pkg::IN_Y_LO +: bbp_pkg::COORD_BITS];
  assign in_pt.z  = s_axis_tdata[bbp_pkg::IN_Z_LO +: bbp_pkg::COORD_BITS];
  assign in_u     = s_axis_tdata[bbp_pkg::IN_U_LO +: bbp_pkg::PARAM_W];
  assign in_v     = s_axis_tdata[bbp_pkg::IN_V_LO +: bbp_pkg::PARAM_W];

  // in-place triangle: pairs (0,1) (1,2) (2,3) (0,1) (1,2) (0,1)
  always_comb begin
    case (step)
      3'd1, 3'd4: begin
        op_a = w[1];
        op_b = w[2];
        dest = 2'd1;
      end
      3'd2: begin
        op_a = w[2];
        op_b = w[3];
        dest = 2'd2;
      end
      default: begin
        op_a = w[0];
        op_b = w[1];
        dest = 2'd0;
      end
    endcase
  end

  assign lerp_t = (state == S_VLERP) ? v_reg : u_reg;

  bbp_lerp u_lerp (
    .p1  (op_a),
    .p2  (op_b),
    .t   (lerp_t),
    .res (lerp_res)
  );

  // point store and its registered read port
  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == bbp_pkg::CMD_LOAD) begin
      points[in_index] <= in_pt;
    end
    if (state == S_READ && !col[2]) begin
      rd_data <= points[{row, col[1:0]}];
    end
  end

  // work registers and parameters
  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == bbp_pkg::CMD_EVAL) begin
      u_reg <= (in_u > bbp_pkg::PARAM_ONE) ? bbp_pkg::PARAM_ONE : in_u;
      v_reg <= (in_v > bbp_pkg::PARAM_ONE) ? bbp_pkg::PARAM_ONE : in_v;
    end
    case (state)
      S_READ: begin
        if (col != 3'd0) begin
          w[2'(col - 3'd1)] <= rd_data;
        end
      end
      S_ULERP: begin
        w[dest] <= lerp_res;
        if (step == 3'd5) begin
          rows[row] <= lerp_res;
        end
      end
      S_VLOAD: begin
        w[0] <= rows[0];
        w[1] <= rows[1];
        w[2] <= rows[2];
        w[3] <= rows[3];
      end
      S_VLERP: begin
        w[dest] <= lerp_res;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= 2'd0;
      col   <= 3'd0;
      step  <= 3'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && s_axis_tuser == bbp_pkg::CMD_EVAL) begin
            state <= S_READ;
            row   <= 2'd0;
            col   <= 3'd0;
          end
        end
        S_READ: begin
          col <= col + 3'd1;
          if (col == 3'd4) begin
            state <= S_ULERP;
            step  <= 3'd0;
          end
        end
        S_ULERP: begin
          step <= step + 3'd1;
          if (step == 3'd5) begin
            if (row == 2'd3) begin
              state <= S_VLOAD;
            end else begin
              state <= S_READ;
              row   <= row + 2'd1;
              col   <= 3'd0;
            end
          end
        end
        S_VLOAD: begin
          state <= S_VLERP;
          step  <= 3'd0;
        end
        S_VLERP: begin
          step <= step + 3'd1;
          if (step == 3'd5) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= bbp_pkg::OUT_DATA_W'({bbp_pkg::PARAM_ONE - v_reg, u_reg,
                                            w[0].z, w[0].y, w[0].x});
    end
  end

endmodule
